// File: rtl/i2c_mbe_pkg.sv
package i2c_mbe_pkg;

    // Width of one data byte on the bus.
    localparam int BYTE_BITS = 8;

    // Stream word widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // Configuration register indexes and widths.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT  = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [CFG_DATA_W-1:0] TICKS_PER_US_RST = 8'd1;
    localparam logic [CFG_DATA_W-1:0] ACK_TIMEOUT_RST  = 8'd250;

    // Command codes.
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_START    = 3'd1;
    localparam logic [2:0] CMD_STOP     = 3'd2;
    localparam logic [2:0] CMD_WRITE    = 3'd3;
    localparam logic [2:0] CMD_READ     = 3'd4;
    localparam logic [2:0] CMD_WAIT_ACK = 3'd5;

    // One classified tick as it waits in the queue.
    typedef struct packed {
        logic [2:0]           cmd;
        logic [BYTE_BITS-1:0] tx_byte;
        logic                 send_ack;
        logic                 sda_sample;
    } tick_item_t;

    // Configuration seen by the bit engine.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] ticks_per_us;
        logic [CFG_DATA_W-1:0] ack_timeout;
    } cfg_t;

endpackage

// File: rtl/i2c_mbe_front.sv
module i2c_mbe_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0 up: cmd[2:0], tx_byte[10:3], send_ack[11], sda_sample[12].
    input  logic [i2c_mbe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                                q_valid,
    output i2c_mbe_pkg::tick_item_t             q_item,
    input  logic                                q_pop
);

    i2c_mbe_pkg::tick_item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic [2:0] raw_cmd;
    i2c_mbe_pkg::tick_item_t classified;

    // Unknown command codes are folded into "no command" here.
    assign raw_cmd = s_axis_tdata[2:0];
    always_comb begin
        classified.tx_byte    = s_axis_tdata[10:3];
        classified.send_ack   = s_axis_tdata[11];
        classified.sda_sample = s_axis_tdata[12];
        unique case (raw_cmd) inside
            i2c_mbe_pkg::CMD_START,
            i2c_mbe_pkg::CMD_STOP,
            i2c_mbe_pkg::CMD_WRITE,
            i2c_mbe_pkg::CMD_READ,
            i2c_mbe_pkg::CMD_WAIT_ACK: classified.cmd = raw_cmd;
            default:                   classified.cmd = i2c_mbe_pkg::CMD_NONE;
        endcase
    end

    // Two-entry queue between the front and the engine.
    assign s_axis_tready = (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != 2'd0);
    assign q_item        = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage carries payload only.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

// File: rtl/i2c_mbe_engine.sv
module i2c_mbe_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  i2c_mbe_pkg::cfg_t                   cfg,
    input  logic                                q_valid,
    input  i2c_mbe_pkg::tick_item_t             q_item,
    output logic                                q_pop,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0 up: scl_level[0], sda_level[1], sda_drive_enable[2],
    // busy_res[3], done_res[4], rx_byte[12:5], ack_failed[13], zeros above.
    output logic [i2c_mbe_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam logic [4:0] PH_IDLE  = 5'd0;
    localparam logic [4:0] PH_ST_A  = 5'd1;
    localparam logic [4:0] PH_ST_B  = 5'd2;
    localparam logic [4:0] PH_SP_A  = 5'd3;
    localparam logic [4:0] PH_SP_B  = 5'd4;
    localparam logic [4:0] PH_WR_D  = 5'd5;
    localparam logic [4:0] PH_WR_H  = 5'd6;
    localparam logic [4:0] PH_WR_L  = 5'd7;
    localparam logic [4:0] PH_RD_L  = 5'd8;
    localparam logic [4:0] PH_RD_H  = 5'd9;
    localparam logic [4:0] PH_AK_L  = 5'd10;
    localparam logic [4:0] PH_AK_H  = 5'd11;
    localparam logic [4:0] PH_WA_LO = 5'd12;
    localparam logic [4:0] PH_WA_HI = 5'd13;
    localparam logic [4:0] PH_POLL  = 5'd14;

    localparam int BB = i2c_mbe_pkg::BYTE_BITS;

    logic [4:0]    phase_reg,   phase_next;
    logic [3:0]    bitcnt_reg,  bitcnt_next;
    logic [BB-1:0] shift_reg,   shift_next;
    logic [10:0]   timer_reg,   timer_next;
    logic [7:0]    polls_reg,   polls_next;
    logic          ackch_reg,   ackch_next;
    logic          scl_reg,     scl_next;
    logic          sda_reg,     sda_next;
    logic          fail_reg,    fail_next;
    logic          drive_reg,   drive_next;
    logic [BB-1:0] rxhold_reg,  rxhold_next;
    logic          done_next;
    logic          mvalid_reg,  mvalid_next;
    logic [i2c_mbe_pkg::OUT_TDATA_W-1:0] mdata_reg, mdata_next;

    logic [7:0]  ticks_eff;
    logic [10:0] dly_1us;
    logic [10:0] dly_2us;
    logic [10:0] dly_4us;
    logic [3:0]  bitcnt_inc;

    // Phase lengths in ticks, minus one for the tick of entry.
    assign ticks_eff  = (cfg.ticks_per_us == 8'd0) ? 8'd1 : cfg.ticks_per_us;
    assign dly_1us    = {3'b000, ticks_eff} - 11'd1;
    assign dly_2us    = {2'b00, ticks_eff, 1'b0} - 11'd1;
    assign dly_4us    = {1'b0, ticks_eff, 2'b00} - 11'd1;
    assign bitcnt_inc = bitcnt_reg + 4'd1;

    // A tick is taken whenever the output register is free or being drained.
    assign q_pop = q_valid && (!mvalid_reg || m_axis_tready);

    // One bus tick of the bit engine.
    always_comb begin
        phase_next  = phase_reg;
        bitcnt_next = bitcnt_reg;
        shift_next  = shift_reg;
        timer_next  = timer_reg;
        polls_next  = polls_reg;
        ackch_next  = ackch_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        fail_next   = fail_reg;
        drive_next  = drive_reg;
        rxhold_next = rxhold_reg;
        done_next   = 1'b0;
        if (phase_reg == PH_IDLE) begin
            unique case (q_item.cmd)
                i2c_mbe_pkg::CMD_START: begin
                    drive_next = 1'b1;
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    phase_next = PH_ST_A;
                    timer_next = dly_4us;
                end
                i2c_mbe_pkg::CMD_STOP: begin
                    drive_next = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    phase_next = PH_SP_A;
                    timer_next = dly_4us;
                end
                i2c_mbe_pkg::CMD_WRITE: begin
                    drive_next  = 1'b1;
                    scl_next    = 1'b0;
                    bitcnt_next = 4'd0;
                    sda_next    = q_item.tx_byte[BB-1];
                    shift_next  = {q_item.tx_byte[BB-2:0], 1'b0};
                    phase_next  = PH_WR_D;
                    timer_next  = dly_2us;
                end
                i2c_mbe_pkg::CMD_READ: begin
                    drive_next  = 1'b0;
                    scl_next    = 1'b0;
                    ackch_next  = q_item.send_ack;
                    bitcnt_next = 4'd0;
                    shift_next  = '0;
                    phase_next  = PH_RD_L;
                    timer_next  = dly_2us;
                end
                i2c_mbe_pkg::CMD_WAIT_ACK: begin
                    drive_next = 1'b0;
                    sda_next   = 1'b1;
                    fail_next  = 1'b0;
                    polls_next = 8'd0;
                    phase_next = PH_WA_LO;
                    timer_next = dly_1us;
                end
                default: begin
                end
            endcase
        end else if (phase_reg == PH_POLL) begin
            // Poll SDA once per tick while SCL is high.
            if (!q_item.sda_sample) begin
                scl_next   = 1'b0;
                phase_next = PH_IDLE;
                done_next  = 1'b1;
            end else if (polls_reg == cfg.ack_timeout) begin
                fail_next  = 1'b1;
                drive_next = 1'b1;
                scl_next   = 1'b0;
                sda_next   = 1'b0;
                phase_next = PH_SP_A;
                timer_next = dly_4us;
            end else begin
                polls_next = polls_reg + 8'd1;
            end
        end else if (timer_reg != 11'd0) begin
            timer_next = timer_reg - 11'd1;
        end else begin
            unique case (phase_reg)
                PH_ST_A: begin
                    sda_next   = 1'b0;
                    phase_next = PH_ST_B;
                    timer_next = dly_4us;
                end
                PH_ST_B: begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                PH_SP_A: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = PH_SP_B;
                    timer_next = dly_4us;
                end
                PH_SP_B: begin
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                PH_WR_D: begin
                    scl_next   = 1'b1;
                    phase_next = PH_WR_H;
                    timer_next = dly_2us;
                end
                PH_WR_H: begin
                    scl_next   = 1'b0;
                    phase_next = PH_WR_L;
                    timer_next = dly_2us;
                end
                PH_WR_L: begin
                    bitcnt_next = bitcnt_inc;
                    if (bitcnt_inc >= 4'(BB)) begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end else begin
                        sda_next   = shift_reg[BB-1];
                        shift_next = {shift_reg[BB-2:0], 1'b0};
                        phase_next = PH_WR_D;
                        timer_next = dly_2us;
                    end
                end
                PH_RD_L: begin
                    scl_next   = 1'b1;
                    shift_next = {shift_reg[BB-2:0], q_item.sda_sample};
                    phase_next = PH_RD_H;
                    timer_next = dly_1us;
                end
                PH_RD_H: begin
                    bitcnt_next = bitcnt_inc;
                    scl_next    = 1'b0;
                    if (bitcnt_inc >= 4'(BB)) begin
                        rxhold_next = shift_reg;
                        drive_next  = 1'b1;
                        sda_next    = !ackch_reg;
                        phase_next  = PH_AK_L;
                        timer_next  = dly_2us;
                    end else begin
                        phase_next = PH_RD_L;
                        timer_next = dly_2us;
                    end
                end
                PH_AK_L: begin
                    scl_next   = 1'b1;
                    phase_next = PH_AK_H;
                    timer_next = dly_2us;
                end
                PH_AK_H: begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done_next  = 1'b1;
                end
                PH_WA_LO: begin
                    scl_next   = 1'b1;
                    phase_next = PH_WA_HI;
                    timer_next = dly_1us;
                end
                PH_WA_HI: begin
                    phase_next = PH_POLL;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Result word built from the updated state.
    always_comb begin
        mdata_next = {2'b00, fail_next, rxhold_next, done_next,
                      (phase_next != PH_IDLE), drive_next, sda_next, scl_next};
        if (q_pop) begin
            mvalid_next = 1'b1;
        end else if (m_axis_tready) begin
            mvalid_next = 1'b0;
        end else begin
            mvalid_next = mvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            bitcnt_reg <= 4'd0;
            shift_reg  <= '0;
            timer_reg  <= 11'd0;
            polls_reg  <= 8'd0;
            ackch_reg  <= 1'b0;
            scl_reg    <= 1'b1;
            sda_reg    <= 1'b1;
            fail_reg   <= 1'b0;
            drive_reg  <= 1'b1;
            rxhold_reg <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            mvalid_reg <= mvalid_next;
            if (q_pop) begin
                phase_reg  <= phase_next;
                bitcnt_reg <= bitcnt_next;
                shift_reg  <= shift_next;
                timer_reg  <= timer_next;
                polls_reg  <= polls_next;
                ackch_reg  <= ackch_next;
                scl_reg    <= scl_next;
                sda_reg    <= sda_next;
                fail_reg   <= fail_next;
                drive_reg  <= drive_next;
                rxhold_reg <= rxhold_next;
            end
        end
    end

    // Output word register holds while the receiver stalls.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            mdata_reg <= mdata_next;
        end
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;

endmodule

// File: rtl/i2c_master_bit_engine.sv
// I2C master bit engine.
// Each word on the s_axis channel is one tick of bus time: an optional
// command (start, stop, write byte, read byte with ACK/NACK, wait for ACK)
// plus the SDA level sampled on that tick. Commands that arrive while a
// command is in progress are ignored. Every input word yields exactly one
// word on m_axis with the SCL level, the SDA level and drive enable, busy,
// a done pulse, the last received byte and the ACK-timeout flag.
// Phase lengths are 1, 2 or 4 microseconds of ticks, set by register 0
// (ticks per microsecond); register 1 sets the wait-for-ACK poll limit.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce it. An
// accepted word is written into the queue, then taken by the engine, whose
// step loads the output register that drives m_axis.
// Throughput: one word per cycle while the receiver is not stalling m_axis;
// the engine step and its output register then both turn over every cycle.
// A two-entry queue sits between input and engine, so a stalled receiver
// holds the output word and the queue absorbs up to two more input words
// before s_axis_tready drops. Reset empties the queue and output register
// and returns the bus state to idle with SCL and SDA high and SDA driven.
module i2c_master_bit_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0 up: cmd[2:0], tx_byte[10:3], send_ack[11], sda_sample[12].
    input  logic [i2c_mbe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0 up: scl_level[0], sda_level[1], sda_drive_enable[2],
    // busy_res[3], done_res[4], rx_byte[12:5], ack_failed[13], zeros above.
    output logic [i2c_mbe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [i2c_mbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [i2c_mbe_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    i2c_mbe_pkg::cfg_t       cfg_reg;
    i2c_mbe_pkg::cfg_t       cfg_next;
    i2c_mbe_pkg::tick_item_t q_item;
    logic                    q_valid;
    logic                    q_pop;

    // Configuration register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                i2c_mbe_pkg::CFG_TICKS_PER_US: cfg_next.ticks_per_us = cfg_wdata;
                i2c_mbe_pkg::CFG_ACK_TIMEOUT:  cfg_next.ack_timeout  = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ticks_per_us <= i2c_mbe_pkg::TICKS_PER_US_RST;
            cfg_reg.ack_timeout  <= i2c_mbe_pkg::ACK_TIMEOUT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    i2c_mbe_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    i2c_mbe_engine u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // A completed command never reports busy in the same word.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[4] |-> !m_axis_tdata[3])
        else $error("done reported together with busy");

    // The engine only pops a tick the queue actually holds.
    a_pop_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("engine popped an empty queue");

    // No result word is offered right after reset.
    a_reset_clears_out: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_axis_tvalid)
        else $error("output valid after reset");

    // A full queue with a stalled output keeps the input side closed.
    a_full_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready && m_axis_tvalid && !m_axis_tready |=> !s_axis_tready)
        else $error("input opened while queue full and output stalled");

endmodule
